@@ src/ctmh_pkg.sv @@
// Package for the circular two-means heading core: shared types, constants, CORDIC table.
// Used by the design modules of the block; no dependencies.
package ctmh_pkg;

    localparam int unsigned DEF_MAX_SAMPLES  = 1024;
    localparam int unsigned DEF_ANGLE_BITS   = 16;
    localparam int unsigned DEF_CORDIC_STEPS = 16;
    localparam logic [7:0]  LIMIT_RESET      = 8'd100;
    localparam int unsigned HEAD_W           = 16;
    localparam int unsigned PATH_W           = 3;
    localparam int unsigned CNT_W            = 11;
    // sums are kept wide enough for any set size
    localparam int unsigned SUM_W            = 40;
    // atan2 works on sums times 2^16 plus CORDIC growth
    localparam int unsigned VEC_W            = 64;

    typedef enum logic [2:0] {
        PATH_SINGLE   = 3'd0,
        PATH_NOCONV   = 3'd1,
        PATH_ONE      = 3'd2,
        PATH_CLOSE    = 3'd3,
        PATH_FLIP     = 3'd4
    } t_path;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SEED,
        ST_ITER_START,
        ST_WALK,
        ST_VEC0_START,
        ST_VEC0_WAIT,
        ST_VEC1_START,
        ST_VEC1_WAIT,
        ST_CHECK,
        ST_FINAL_START,
        ST_FINAL_WAIT,
        ST_OUT
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic store;        // write incoming angle
        logic clr_count;    // restart loading
        logic seed_start;   // begin min search pass
        logic iter_start;   // clear sums, start walk
        logic vec0_start;   // atan2 of cluster 0
        logic vec1_start;   // atan2 of cluster 1
        logic check;        // update means, convergence test
        logic final_start;  // pick final path, start final atan2
        logic out_load;     // capture result word
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic seed_done;
        logic walk_done;
        logic vec_done;
        logic conv;
        logic single;
        logic need_vec;     // final path needs atan2
        logic iter_over;    // iteration limit reached
    } t_stat;

    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] r;
        unique case (i)
            5'd0:  r = 32'h20000000; 5'd1:  r = 32'h12E4051E;
            5'd2:  r = 32'h09FB385B; 5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43; 5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E; 5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53; 5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA; 5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C; 5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
            5'd24: r = 32'h00000029; 5'd25: r = 32'h00000014;
            5'd26: r = 32'h0000000A; 5'd27: r = 32'h00000005;
            5'd28: r = 32'h00000003; 5'd29: r = 32'h00000001;
            5'd30: r = 32'h00000001; default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

@@ src/ctmh_if.sv @@
// Valid/ready channel interfaces for the heading core.
// Field widths are set here; no dependency on ctmh_pkg.
interface ctmh_in_if #(parameter int unsigned ANGLE_BITS = 16);
    logic                  valid;
    logic                  ready;
    logic [ANGLE_BITS-1:0] sample_angle;
    logic                  last_sample;
    modport source (output valid, sample_angle, last_sample, input ready);
    modport sink   (input valid, sample_angle, last_sample, output ready);
endinterface

interface ctmh_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] heading;
    logic [2:0]  path_taken;
    logic [10:0] sample_count;
    modport source (output valid, heading, path_taken, sample_count, input ready);
    modport sink   (input valid, heading, path_taken, sample_count, output ready);
endinterface

@@ src/ctmh_sincos.sv @@
// Iterative rotation CORDIC: one micro-rotation per cycle, sine and cosine at scale 2^15 times the CORDIC gain.
// Depends on ctmh_pkg for the arctangent table.
module ctmh_sincos
    import ctmh_pkg::*;
#(
    parameter int unsigned ANGLE_BITS   = DEF_ANGLE_BITS,
    parameter int unsigned CORDIC_STEPS = DEF_CORDIC_STEPS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [ANGLE_BITS-1:0] i_angle,
    output logic                  o_done,
    output logic signed [17:0]    o_cos,
    output logic signed [17:0]    o_sin
);
    localparam int unsigned SW = $clog2(CORDIC_STEPS + 1);

    logic               r_busy, n_busy;
    logic [SW-1:0]      r_step, n_step;
    logic signed [33:0] r_x, n_x, r_y, n_y;
    logic signed [33:0] r_z, n_z;
    logic               r_neg, n_neg;
    logic               r_done;
    logic [31:0]        w_ph;
    logic [31:0]        w_phr;
    logic signed [33:0] w_dx, w_dy, w_xr, w_yr;

    assign w_ph  = {i_angle, {(32-ANGLE_BITS){1'b0}}};
    assign w_phr = (w_ph[31] ^ w_ph[30]) ? w_ph + 32'h80000000 : w_ph;
    assign w_dx  = r_x >>> r_step;
    assign w_dy  = r_y >>> r_step;
    assign w_xr  = (r_x + 34'sd16384) >>> 15;
    assign w_yr  = (r_y + 34'sd16384) >>> 15;

    // step sequencing and micro-rotation
    always_comb begin
        n_busy = r_busy;
        n_step = r_step;
        n_x    = r_x;
        n_y    = r_y;
        n_z    = r_z;
        n_neg  = r_neg;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = '0;
            n_x    = 34'sd1073741824;
            n_y    = '0;
            n_z    = {{2{w_phr[31]}}, w_phr};
            n_neg  = w_ph[31] ^ w_ph[30];
        end else if (r_busy) begin
            if (r_z >= 0) begin
                n_x = r_x - w_dy;
                n_y = r_y + w_dx;
                n_z = r_z - $signed({2'b00, atan_entry(5'(r_step))});
            end else begin
                n_x = r_x + w_dy;
                n_y = r_y - w_dx;
                n_z = r_z + $signed({2'b00, atan_entry(5'(r_step))});
            end
            n_step = r_step + 1'b1;
            if (r_step == SW'(CORDIC_STEPS - 1)) n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= r_busy && !n_busy;
        end
        r_step <= n_step;
        r_x    <= n_x;
        r_y    <= n_y;
        r_z    <= n_z;
        r_neg  <= n_neg;
    end

    assign o_done = r_done;
    assign o_cos  = r_neg ? -w_xr[17:0] : w_xr[17:0];
    assign o_sin  = r_neg ? -w_yr[17:0] : w_yr[17:0];
endmodule

@@ src/ctmh_atan2.sv @@
// Iterative vectoring CORDIC: atan2 of two sums, one micro-rotation per cycle.
// Depends on ctmh_pkg for the arctangent table and widths.
module ctmh_atan2
    import ctmh_pkg::*;
#(
    parameter int unsigned ANGLE_BITS   = DEF_ANGLE_BITS,
    parameter int unsigned CORDIC_STEPS = DEF_CORDIC_STEPS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [SUM_W-1:0] i_y,
    input  logic signed [SUM_W-1:0] i_x,
    output logic                    o_done,
    output logic [ANGLE_BITS-1:0]   o_angle
);
    localparam int unsigned SW = $clog2(CORDIC_STEPS + 1);

    logic                    r_busy, n_busy, r_done;
    logic [SW-1:0]           r_step, n_step;
    logic signed [VEC_W-1:0] r_x, n_x, r_y, n_y;
    logic [31:0]             r_z, n_z;
    logic                    r_zero, n_zero;
    logic signed [VEC_W-1:0] w_xs, w_ys, w_dx, w_dy;
    logic [32:0]             w_round;

    assign w_xs = {{(VEC_W-SUM_W-16){i_x[SUM_W-1]}}, i_x, 16'h0000};
    assign w_ys = {{(VEC_W-SUM_W-16){i_y[SUM_W-1]}}, i_y, 16'h0000};
    assign w_dx = r_x >>> r_step;
    assign w_dy = r_y >>> r_step;

    // step sequencing and micro-rotation
    always_comb begin
        n_busy = r_busy;
        n_step = r_step;
        n_x    = r_x;
        n_y    = r_y;
        n_z    = r_z;
        n_zero = r_zero;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = '0;
            n_zero = (i_x == '0) && (i_y == '0);
            if (i_x < 0) begin
                n_x = -w_xs;
                n_y = -w_ys;
                n_z = 32'h80000000;
            end else begin
                n_x = w_xs;
                n_y = w_ys;
                n_z = '0;
            end
        end else if (r_busy) begin
            if (r_y >= 0) begin
                n_x = r_x + w_dy;
                n_y = r_y - w_dx;
                n_z = r_z + atan_entry(5'(r_step));
            end else begin
                n_x = r_x - w_dy;
                n_y = r_y + w_dx;
                n_z = r_z - atan_entry(5'(r_step));
            end
            n_step = r_step + 1'b1;
            if (r_step == SW'(CORDIC_STEPS - 1)) n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= r_busy && !n_busy;
        end
        r_step <= n_step;
        r_x    <= n_x;
        r_y    <= n_y;
        r_z    <= n_z;
        r_zero <= n_zero;
    end

    // round half up to the angle width, wrapping
    generate
        if (ANGLE_BITS == 32) begin : g_full
            assign w_round = {1'b0, r_z};
        end else begin : g_part
            assign w_round = {1'b0, r_z} + 33'(33'd1 << (31 - ANGLE_BITS));
        end
    endgenerate

    assign o_done  = r_done;
    assign o_angle = r_zero ? '0 : w_round[31 -: ANGLE_BITS];
endmodule

@@ src/ctmh_datapath.sv @@
// Datapath: angle memory, seed search, assignment walk, sums, means and result selection.
// Depends on ctmh_pkg, ctmh_sincos and ctmh_atan2.
module ctmh_datapath
    import ctmh_pkg::*;
#(
    parameter int unsigned MAX_SAMPLES  = DEF_MAX_SAMPLES,
    parameter int unsigned ANGLE_BITS   = DEF_ANGLE_BITS,
    parameter int unsigned CORDIC_STEPS = DEF_CORDIC_STEPS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    input  logic [ANGLE_BITS-1:0] i_angle,
    input  logic [7:0]            i_limit,
    output logic [15:0]           o_heading,
    output logic [2:0]            o_path,
    output logic [10:0]           o_count
);
    localparam int unsigned AW = $clog2(MAX_SAMPLES);
    localparam int unsigned NW = $clog2(MAX_SAMPLES + 1);

    logic [ANGLE_BITS-1:0] r_mem [MAX_SAMPLES];
    logic [ANGLE_BITS-1:0] r_rd;
    logic [ANGLE_BITS-1:0] r_first;
    logic [NW-1:0]         r_n;
    logic [NW-1:0]         r_idx;
    logic                  r_rd_v, r_scan;
    logic                  r_pass;          // 0: minimum pass, 1: second pass
    logic                  r_have2;
    logic [ANGLE_BITS-1:0] r_mn, r_sec;
    logic [ANGLE_BITS-1:0] r_mean [2];
    logic                  r_mv [2];
    logic [ANGLE_BITS-1:0] r_old_mean [2];
    logic                  r_old_v [2];
    logic signed [SUM_W-1:0] r_ssum [2], r_csum [2];
    logic [NW-1:0]         r_cnt [2];
    logic                  r_mark;
    logic                  r_walk;
    logic [NW-1:0]         r_pend;
    logic [7:0]            r_iter;
    logic                  r_conv;
    logic [ANGLE_BITS-1:0] r_v0;
    logic                  r_seed_done, r_walk_done;
    logic [2:0]            r_path;
    logic [ANGLE_BITS-1:0] r_head;
    logic                  r_need_vec;
    logic                  w_sc_done, w_at_done;
    logic signed [17:0]    w_cos, w_sin;
    logic [ANGLE_BITS-1:0] w_at;
    logic signed [SUM_W-1:0] w_vy, w_vx;
    logic [1:0]            r_vsrc;
    logic                  w_m;
    logic [ANGLE_BITS-1:0] w_d0, w_d1, w_dm;
    logic [ANGLE_BITS:0]   w_w0, w_w1, w_wm;
    logic [AW-1:0]         w_raddr;

    // wrapped distance helper
    function automatic logic [ANGLE_BITS:0] wd(input logic [ANGLE_BITS-1:0] d);
        logic [ANGLE_BITS:0] o;
        o = (ANGLE_BITS+1)'(1) << ANGLE_BITS;
        o = o - {1'b0, d};
        return ({1'b0, d} < o) ? {1'b0, d} : o;
    endfunction

    assign w_raddr = r_idx[AW-1:0];
    assign w_d0 = r_rd - r_mean[0];
    assign w_d1 = r_rd - r_mean[1];
    assign w_w0 = wd(w_d0);
    assign w_w1 = wd(w_d1);
    assign w_m  = r_mv[1] && (!r_mv[0] || (w_w1 < w_w0));
    assign w_dm = r_mean[0] - r_mean[1];
    assign w_wm = wd(w_dm);

    // memory write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.store && (r_n < NW'(MAX_SAMPLES))) r_mem[r_n[AW-1:0]] <= i_angle;
        r_rd <= r_mem[w_raddr];
    end

    // loading count and first angle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n <= '0;
        end else if (i_cmd.clr_count) begin
            r_n <= '0;
        end else if (i_cmd.store && (r_n < NW'(MAX_SAMPLES))) begin
            r_n <= r_n + 1'b1;
        end
        if (i_cmd.store && (r_n == '0)) r_first <= i_angle;
    end

    ctmh_sincos #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_sincos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_walk && r_rd_v),
        .i_angle (r_rd),
        .o_done  (w_sc_done),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    // atan2 operand selection
    always_comb begin
        unique case (r_vsrc)
            2'd0: begin w_vy = r_ssum[0]; w_vx = r_csum[0]; end
            2'd1: begin w_vy = r_ssum[1]; w_vx = r_csum[1]; end
            2'd2: begin w_vy = r_ssum[0] + r_ssum[1]; w_vx = r_csum[0] + r_csum[1]; end
            default: begin
                if (r_cnt[0] > r_cnt[1]) begin
                    w_vy = r_ssum[0] - r_ssum[1]; w_vx = r_csum[0] - r_csum[1];
                end else begin
                    w_vy = r_ssum[1] - r_ssum[0]; w_vx = r_csum[1] - r_csum[0];
                end
            end
        endcase
    end

    logic r_at_start;
    ctmh_atan2 #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_atan2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_at_start),
        .i_y     (w_vy),
        .i_x     (w_vx),
        .o_done  (w_at_done),
        .o_angle (w_at)
    );

    // scan, walk, cluster update and result control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan      <= 1'b0;
            r_walk      <= 1'b0;
            r_rd_v      <= 1'b0;
            r_seed_done <= 1'b0;
            r_walk_done <= 1'b0;
            r_at_start  <= 1'b0;
            r_idx       <= '0;
            r_iter      <= '0;
            r_mv[0]     <= 1'b0;
            r_mv[1]     <= 1'b0;
            r_pend      <= '0;
            r_vsrc      <= 2'd0;
        end else begin
            r_seed_done <= 1'b0;
            r_walk_done <= 1'b0;
            r_at_start  <= 1'b0;
            r_rd_v      <= 1'b0;
            // seed search: min pass then second-smallest pass
            if (i_cmd.seed_start) begin
                r_scan  <= 1'b1;
                r_pass  <= 1'b0;
                r_idx   <= '0;
                r_have2 <= 1'b0;
                r_iter  <= '0;
            end else if (r_scan) begin
                if (r_idx < r_n) begin
                    r_idx  <= r_idx + 1'b1;
                    r_rd_v <= 1'b1;
                end
                if (r_rd_v) begin
                    if (!r_pass) begin
                        if (r_idx == NW'(1) || r_rd < r_mn) r_mn <= r_rd;
                    end else if (r_rd > r_mn && (!r_have2 || r_rd < r_sec)) begin
                        r_sec   <= r_rd;
                        r_have2 <= 1'b1;
                    end
                end
                if (r_idx == r_n && !r_rd_v && r_idx != '0) begin
                    if (!r_pass) begin
                        r_pass <= 1'b1;
                        r_idx  <= '0;
                    end else begin
                        r_scan      <= 1'b0;
                        r_seed_done <= 1'b1;
                        r_mean[0]   <= r_mn;
                        r_mv[0]     <= 1'b1;
                        r_mean[1]   <= r_have2 ? r_sec : '0;
                        r_mv[1]     <= r_have2;
                    end
                end
            end
            // assignment walk, one angle per sincos run
            if (i_cmd.iter_start) begin
                r_walk    <= 1'b1;
                r_idx     <= '0;
                r_pend    <= '0;
                r_ssum[0] <= '0; r_ssum[1] <= '0;
                r_csum[0] <= '0; r_csum[1] <= '0;
                r_cnt[0]  <= '0; r_cnt[1]  <= '0;
            end else if (r_walk) begin
                if (r_idx == r_pend && r_idx < r_n) begin
                    r_idx  <= r_idx + 1'b1;
                    r_rd_v <= 1'b1;
                end
                if (r_rd_v) r_mark <= w_m;
                if (w_sc_done) begin
                    r_pend <= r_pend + 1'b1;
                    r_ssum[r_mark] <= r_ssum[r_mark] + SUM_W'(w_sin);
                    r_csum[r_mark] <= r_csum[r_mark] + SUM_W'(w_cos);
                    r_cnt[r_mark]  <= r_cnt[r_mark] + 1'b1;
                    if (r_pend + 1'b1 == r_n) begin
                        r_walk      <= 1'b0;
                        r_walk_done <= 1'b1;
                    end
                end
            end
            // per-cluster atan2
            if (i_cmd.vec0_start) begin
                r_vsrc <= 2'd0;
                r_at_start <= 1'b1;
                r_old_mean[0] <= r_mean[0]; r_old_v[0] <= r_mv[0];
                r_old_mean[1] <= r_mean[1]; r_old_v[1] <= r_mv[1];
            end
            if (i_cmd.vec1_start) begin
                r_vsrc <= 2'd1;
                r_at_start <= 1'b1;
                r_v0 <= w_at;
            end
            if (i_cmd.check) begin
                r_mv[0] <= r_cnt[0] != '0;
                if (r_cnt[0] != '0) r_mean[0] <= r_v0;
                r_mv[1] <= r_cnt[1] != '0;
                if (r_cnt[1] != '0) r_mean[1] <= w_at;
                r_iter <= r_iter + 1'b1;
            end
            if (i_cmd.final_start) begin
                r_need_vec <= 1'b0;
                if (!r_conv) begin
                    r_path <= PATH_NOCONV; r_head <= r_first;
                end else if (r_cnt[0] == '0) begin
                    r_path <= PATH_ONE; r_head <= r_mean[1];
                end else if (r_cnt[1] == '0) begin
                    r_path <= PATH_ONE; r_head <= r_mean[0];
                end else begin
                    r_need_vec <= 1'b1;
                    r_at_start <= 1'b1;
                    if (w_wm < ((ANGLE_BITS+1)'(1) << (ANGLE_BITS-2))) begin
                        r_path <= PATH_CLOSE; r_vsrc <= 2'd2;
                    end else begin
                        r_path <= PATH_FLIP;  r_vsrc <= 2'd3;
                    end
                end
            end
            if (i_cmd.out_load) begin
                if (r_n == NW'(1)) begin
                    r_path <= PATH_SINGLE; r_head <= r_first;
                end else if (r_need_vec) begin
                    r_head <= w_at;
                end
            end
        end
    end

    // convergence: both means unchanged in validity and value
    logic w_c0, w_c1, w_nv0, w_nv1;
    assign w_nv0 = r_cnt[0] != '0;
    assign w_nv1 = r_cnt[1] != '0;
    assign w_c0 = (!r_old_v[0] && !w_nv0) || (r_old_v[0] && w_nv0 && r_old_mean[0] == r_v0);
    assign w_c1 = (!r_old_v[1] && !w_nv1) || (r_old_v[1] && w_nv1 && r_old_mean[1] == w_at);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conv <= 1'b0;
        end else if (i_cmd.seed_start) begin
            r_conv <= 1'b0;
        end else if (i_cmd.check) begin
            r_conv <= w_c0 && w_c1;
        end
    end

    assign o_stat.seed_done = r_seed_done;
    assign o_stat.walk_done = r_walk_done;
    assign o_stat.vec_done  = w_at_done;
    assign o_stat.conv      = w_c0 && w_c1;
    assign o_stat.single    = (r_n == NW'(1));
    assign o_stat.need_vec  = r_need_vec;
    assign o_stat.iter_over = (r_iter >= i_limit);

    assign o_heading = 16'(r_head);
    assign o_path    = r_path;
    assign o_count   = 11'(r_n);
endmodule

@@ src/ctmh_ctrl.sv @@
// Controller state machine: loading, seeding, k-means iterations and result handoff.
// Depends on ctmh_pkg for state and command types.
module ctmh_ctrl
    import ctmh_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_in_last,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    t_state r_state, n_state;
    logic   w_acc;

    assign w_acc = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_LOAD;
        else          r_state <= n_state;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD:        if (w_acc && i_in_last) n_state = ST_SEED;
            ST_SEED:        if (i_stat.single) n_state = ST_OUT;
                            else if (i_stat.seed_done) n_state = ST_ITER_START;
            ST_ITER_START:  n_state = i_stat.iter_over ? ST_FINAL_START : ST_WALK;
            ST_WALK:        if (i_stat.walk_done) n_state = ST_VEC0_START;
            ST_VEC0_START:  n_state = ST_VEC0_WAIT;
            ST_VEC0_WAIT:   if (i_stat.vec_done) n_state = ST_VEC1_START;
            ST_VEC1_START:  n_state = ST_VEC1_WAIT;
            ST_VEC1_WAIT:   if (i_stat.vec_done) n_state = ST_CHECK;
            ST_CHECK:       n_state = i_stat.conv ? ST_FINAL_START : ST_ITER_START;
            ST_FINAL_START: n_state = ST_FINAL_WAIT;
            ST_FINAL_WAIT:  if (!i_stat.need_vec || i_stat.vec_done) n_state = ST_OUT;
            ST_OUT:         if (i_out_ready) n_state = ST_LOAD;
            default:        n_state = ST_LOAD;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd       = '0;
        o_in_ready  = (r_state == ST_LOAD);
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_LOAD:        o_cmd.store = w_acc;
            ST_SEED:        o_cmd.seed_start = 1'b0;
            ST_ITER_START:  o_cmd.iter_start = !i_stat.iter_over;
            ST_VEC0_START:  o_cmd.vec0_start = 1'b1;
            ST_VEC1_START:  o_cmd.vec1_start = 1'b1;
            ST_CHECK:       o_cmd.check = 1'b1;
            ST_FINAL_START: o_cmd.final_start = 1'b1;
            ST_FINAL_WAIT:  o_cmd.out_load = !i_stat.need_vec || i_stat.vec_done;
            ST_OUT: begin
                o_out_valid     = 1'b1;
                o_cmd.clr_count = i_out_ready;
            end
            default: ;
        endcase
        // seed search starts on the cycle the last word lands
        if (r_state == ST_LOAD && w_acc && i_in_last) o_cmd.seed_start = 1'b1;
        if (r_state == ST_SEED && i_stat.single) o_cmd.out_load = 1'b1;
    end
endmodule

@@ src/circular_two_means_heading_core.sv @@
// Circular two-means heading core: loads one angle word per cycle while ready, then clusters.
// Per k-means iteration each stored angle goes through the sincos unit in turn, then two atan2
// runs follow; seeding takes two passes over the stored angles.
// Throughput: one set at a time; input is stalled until the result word is taken.
// Reset (synchronous, active low) empties the set and loads the iteration limit with 100.
module circular_two_means_heading_core
    import ctmh_pkg::*;
#(
    parameter int unsigned MAX_SAMPLES  = DEF_MAX_SAMPLES,
    parameter int unsigned ANGLE_BITS   = DEF_ANGLE_BITS,
    parameter int unsigned CORDIC_STEPS = DEF_CORDIC_STEPS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    ctmh_in_if.sink    i_in,
    ctmh_out_if.source o_out
);
    logic [7:0] r_limit;
    t_cmd       w_cmd;
    t_stat      w_stat;

    // iteration limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)      r_limit <= LIMIT_RESET;
        else if (i_cfg_we) r_limit <= i_cfg_wdata;
    end

    ctmh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_last   (i_in.last_sample),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    ctmh_datapath #(
        .MAX_SAMPLES  (MAX_SAMPLES),
        .ANGLE_BITS   (ANGLE_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .o_stat    (w_stat),
        .i_angle   (i_in.sample_angle),
        .i_limit   (r_limit),
        .o_heading (o_out.heading),
        .o_path    (o_out.path_taken),
        .o_count   (o_out.sample_count)
    );
endmodule

@@ src/ctmh_checker.sv @@
// Port-level checker for the heading core, attached by bind.
// Depends on the channel interfaces only through the top level's ports.
module ctmh_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] heading,
    input logic [2:0]  path_taken,
    input logic [10:0] sample_count
);
    // no input taken while a result word is offered
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> !in_ready) else $error("input ready during result");

    // path code stays in range
    a_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> (path_taken <= 3'd4)) else $error("bad path code");

    // single-sample path only for a set of one
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && path_taken == 3'd0) |-> (sample_count == 11'd1))
        else $error("single path with many samples");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(heading)))
        else $error("result dropped");
endmodule

bind circular_two_means_heading_core ctmh_checker u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .in_ready     (i_in.ready),
    .out_valid    (o_out.valid),
    .out_ready    (o_out.ready),
    .heading      (o_out.heading),
    .path_taken   (o_out.path_taken),
    .sample_count (o_out.sample_count)
);
